// ----- rtl/open_addressing_hash_table_assert.svh -----
// assertion macros for the open addressing hash table
// used by the top level only; expects clk and rst in scope
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// property that holds at every clock edge out of reset
`define OAHT_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

// property that holds in the cycle after a trigger
`define OAHT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/oaht_pkg.sv -----
// shared types, codes and constants of the open addressing hash table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package oaht_pkg;

  // field widths fixed by the transaction formats
  localparam int KEY_W = 32;
  localparam int VALUE_W = 32;
  localparam int HASH_W = 31;
  localparam int COUNT_W = 11;

  // parameter defaults
  localparam int MAX_SLOTS_DEF = 1024;
  localparam int INITIAL_SIZE_DEF = 11;
  localparam int DIV_W_DEF = 12;

  // register port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam logic [1:0] REG_PROBE_MODE = 2'd0;
  localparam logic [1:0] REG_MAX_LOAD = 2'd1;
  localparam logic [1:0] REG_MIN_LOAD = 2'd2;
  localparam logic [7:0] MAX_LOAD_RST = 8'd192;
  localparam logic [7:0] MIN_LOAD_RST = 8'd0;

  // probe modes; the unused code probes as linear
  localparam logic [1:0] PM_LINEAR = 2'd0;
  localparam logic [1:0] PM_QUAD = 2'd1;
  localparam logic [1:0] PM_DOUBLE = 2'd2;

  typedef enum logic [1:0] {
    FN_PUT = 2'd0,
    FN_GET = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    RS_SUCCESS = 2'd0,
    RS_NOT_FOUND = 2'd1,
    RS_NO_ROOM = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MK_EMPTY = 2'd0,
    MK_FULL = 2'd1,
    MK_DELETED = 2'd2
  } mark_t;

  // what a finished prime search feeds
  typedef enum logic [1:0] {
    PC_GROW,
    PC_SHRINK,
    PC_NSP
  } ps_ctx_t;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HMOD_GO,
    ST_HMOD_WAIT,
    ST_SMOD_GO,
    ST_SMOD_WAIT,
    ST_PROBE_RD,
    ST_PROBE_EV,
    ST_GROW_CHK,
    ST_SHRINK_CHK,
    ST_PS_STEP,
    ST_PT_CHK,
    ST_PT_GO,
    ST_PT_WAIT,
    ST_PS_FOUND,
    ST_RB_RD,
    ST_RB_EV,
    ST_RB_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    func_t func;
    logic [KEY_W-1:0] item_key;
    logic [HASH_W-1:0] key_hash;
    logic [VALUE_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    status_t status;
    logic found;
    logic [VALUE_W-1:0] value_out;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

  // one slot of the table
  typedef struct packed {
    mark_t mark;
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0] key;
    logic [VALUE_W-1:0] value;
  } entry_t;

  // control and status of the shared divider
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

  // largest prime below n, or 1; elaboration only
  function automatic int prime_below_c(input int n);
    int m;
    int d;
    int r;
    bit prime_flag;
    m = n;
    while (m > 2) begin
      m = m - 1;
      prime_flag = 1'b1;
      for (d = 2; d * d <= m; d++) begin
        r = m;
        while (r >= d) r = r - d;
        if (r == 0) prime_flag = 1'b0;
      end
      if (prime_flag) return m;
    end
    return 1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/oaht_divmod.sv -----
// bit-serial restoring divider returning the remainder of a hash-wide dividend
// depends on oaht_pkg
`timescale 1ns / 1ps
`default_nettype none

module oaht_divmod #(
  parameter int DIV_W = oaht_pkg::DIV_W_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire oaht_pkg::div_ctl_t ctl,
  input  wire logic [oaht_pkg::HASH_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output oaht_pkg::div_sts_t sts,
  output logic [DIV_W-1:0] remainder
);
  import oaht_pkg::*;

  localparam int CW = $clog2(HASH_W + 1);

  logic [DIV_W-1:0] dsr;
  logic [HASH_W-1:0] dvd;
  logic [CW-1:0] cnt;
  logic run;
  logic done;
  logic [DIV_W:0] trial;

  // shift in one dividend bit and try a subtract
  assign trial = {remainder, dvd[HASH_W-1]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= run && (cnt == CW'(1));
      if (ctl.start) begin
        run <= 1'b1;
      end else if (run && (cnt == CW'(1))) begin
        run <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      remainder <= '0;
      dvd <= dividend;
      dsr <= divisor;
      cnt <= CW'(HASH_W);
    end else if (run) begin
      if (trial >= {1'b0, dsr}) begin
        remainder <= DIV_W'(trial - {1'b0, dsr});
      end else begin
        remainder <= DIV_W'(trial);
      end
      dvd <= dvd << 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign sts.done = done;

endmodule

`default_nettype wire

// ----- rtl/open_addressing_hash_table.sv -----
// Open addressing key/value table with prime-sized capacity held in two banks of a
// slot memory with one read and one write port; put, get, remove and clear each
// return one transaction.
// A put, get or remove first reduces the hash modulo the table size on a bit-serial
// divider (and modulo the step prime for the step in double hashing mode), then reads
// and evaluates each probed slot. A put that reaches the grow threshold or a remove
// that reaches the shrink threshold also runs a prime search by trial division on the
// same divider, sweeps the target bank clear over every slot of the new size and
// re-inserts every full slot. A clear sweeps every slot of the larger of the current
// and initial size. After reset the block sweeps the initial size of bank zero before
// it accepts a transaction; register writes are taken at all times. Depends on
// oaht_pkg and oaht_divmod.
`timescale 1ns / 1ps
`default_nettype none

`include "open_addressing_hash_table_assert.svh"

module open_addressing_hash_table #(
  parameter int MAX_SLOTS = oaht_pkg::MAX_SLOTS_DEF,
  parameter int INITIAL_SIZE = oaht_pkg::INITIAL_SIZE_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic req_ready,
  input  wire oaht_pkg::req_t req,
  output logic rsp_valid,
  input  wire logic rsp_ready,
  output oaht_pkg::rsp_t rsp,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [oaht_pkg::PADDR_W-1:0] paddr,
  input  wire logic [oaht_pkg::PDATA_W-1:0] pwdata,
  output logic [oaht_pkg::PDATA_W-1:0] prdata,
  output logic pready
);
  import oaht_pkg::*;

  localparam int INIT_EFF = (INITIAL_SIZE < MAX_SLOTS) ? INITIAL_SIZE : MAX_SLOTS;
  localparam int INIT_SP = prime_below_c(INIT_EFF);
  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int NW = $clog2(2 * MAX_SLOTS + 2);
  localparam int DEPTH = 2 * MAX_SLOTS;
  localparam int MW = $clog2(DEPTH);
  localparam int LW = SW + 8;

  // table state
  state_t state, state_next;
  logic active_bank;
  logic [SW-1:0] table_size;
  logic [SW-1:0] step_prime;
  logic [SW-1:0] element_count;
  logic [1:0] probe_mode;
  logic [7:0] max_load;
  logic [7:0] min_load;

  // current transaction and probe context
  func_t op_func;
  logic [KEY_W-1:0] p_key;
  logic [HASH_W-1:0] p_hash;
  logic [VALUE_W-1:0] p_val;
  logic p_bank;
  logic p_put;
  logic [SW-1:0] p_size;
  logic [SW-1:0] p_sp;
  logic [SW-1:0] pos;
  logic [SW-1:0] delta;
  logic [SW-1:0] pi;

  // result
  status_t res_status;
  logic res_found;
  logic [VALUE_W-1:0] res_value;

  // clearing sweep
  logic sw_bank;
  logic [SW-1:0] sw_idx;
  logic [SW-1:0] sw_end;
  state_t sw_ret;

  // prime search
  logic [NW-1:0] ps_n;
  logic ps_up;
  ps_ctx_t ps_ctx;
  logic [NW-1:0] pt_d;
  logic [NW:0] pt_dsq;

  // rebuild
  logic rb_active;
  logic [SW-1:0] rb_src;
  logic [SW-1:0] rb_cnt;
  logic [SW-1:0] tgt_size;
  logic [SW-1:0] new_sp;

  // slot memory
  entry_t mem [DEPTH];
  entry_t rd_q;
  entry_t wr_data;
  logic [MW-1:0] rd_addr;
  logic [MW-1:0] wr_addr;
  logic wr_en;

  // divider
  div_ctl_t div_ctl;
  div_sts_t div_sts;
  logic [HASH_W-1:0] div_a;
  logic [NW-1:0] div_b;
  logic [NW-1:0] div_rem;

  // probe evaluation
  logic is_full;
  logic key_match;
  logic last_probe;
  logic pr_ok;
  logic pr_fail;
  logic pr_adv;
  logic [SW:0] pos_sum;
  logic [SW:0] dlt_sum;
  logic [SW-1:0] pos_next;
  logic [SW-1:0] delta_next;
  logic grow_hit;
  logic shrink_hit;
  logic shrink_ok;
  logic cfg_wr;
  logic rsp_free;

  function automatic logic [MW-1:0] slot_addr(input logic bank, input logic [SW-1:0] idx);
    return bank ? MW'(idx) + MW'(MAX_SLOTS) : MW'(idx);
  endfunction

  oaht_divmod #(
    .DIV_W(NW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .ctl(div_ctl),
    .dividend(div_a),
    .divisor(div_b),
    .sts(div_sts),
    .remainder(div_rem)
  );

  // slot memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // probe outcome on the slot just read
  assign is_full = (rd_q.mark == MK_FULL);
  assign key_match = is_full && (rd_q.key == p_key) && (rd_q.hash == p_hash);
  assign last_probe = (pi == p_size - 1'b1);
  assign pr_ok = p_put ? (!is_full || key_match) : key_match;
  assign pr_fail = !pr_ok && (p_put ? last_probe : ((rd_q.mark == MK_EMPTY) || last_probe));
  assign pr_adv = !pr_ok && !pr_fail;

  // next probe position and quadratic step
  assign pos_sum = {1'b0, pos} + {1'b0, delta};
  assign pos_next = (pos_sum >= {1'b0, p_size}) ? SW'(pos_sum - {1'b0, p_size}) : SW'(pos_sum);
  assign dlt_sum = {1'b0, delta} + (SW + 1)'(2);
  assign delta_next = (dlt_sum >= {1'b0, p_size}) ? SW'(dlt_sum - {1'b0, p_size})
                                                  : SW'(dlt_sum);

  // load thresholds
  assign grow_hit = ({LW'(element_count), 8'b0} >= (LW + 8)'(LW'(max_load) * LW'(table_size)));
  assign shrink_hit = (min_load != 8'd0) &&
                      ({LW'(element_count), 8'b0} <= (LW + 8)'(LW'(min_load) * LW'(table_size)));
  assign shrink_ok = (ps_n >= NW'(2)) && (ps_n > NW'(element_count));

  assign cfg_wr = psel && penable && pwrite && pready;
  assign rsp_free = !rsp_valid || rsp_ready;
  assign pready = 1'b1;

  // register reads
  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_PROBE_MODE: prdata = PDATA_W'(probe_mode);
      REG_MAX_LOAD: prdata = PDATA_W'(max_load);
      REG_MIN_LOAD: prdata = PDATA_W'(min_load);
      default: prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (sw_idx == sw_end - 1'b1) state_next = sw_ret;
      end
      ST_IDLE: begin
        if (req_valid) state_next = (req.func == FN_CLEAR) ? ST_SWEEP : ST_HMOD_GO;
      end
      ST_HMOD_GO: state_next = ST_HMOD_WAIT;
      ST_HMOD_WAIT: begin
        if (div_sts.done) state_next = (probe_mode == PM_DOUBLE) ? ST_SMOD_GO : ST_PROBE_RD;
      end
      ST_SMOD_GO: state_next = ST_SMOD_WAIT;
      ST_SMOD_WAIT: begin
        if (div_sts.done) state_next = ST_PROBE_RD;
      end
      ST_PROBE_RD: state_next = ST_PROBE_EV;
      ST_PROBE_EV: begin
        if (pr_adv) begin
          state_next = ST_PROBE_RD;
        end else if (rb_active) begin
          state_next = pr_ok ? ST_RB_NEXT : ST_DONE;
        end else if (p_put) begin
          state_next = pr_ok ? ST_GROW_CHK : ST_DONE;
        end else if (pr_ok && (op_func == FN_REMOVE)) begin
          state_next = ST_SHRINK_CHK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_GROW_CHK: state_next = grow_hit ? ST_PS_STEP : ST_DONE;
      ST_SHRINK_CHK: state_next = shrink_hit ? ST_PS_STEP : ST_DONE;
      ST_PS_STEP: begin
        if (ps_up ? (ps_n > NW'(MAX_SLOTS)) : (ps_n <= NW'(2))) begin
          state_next = ST_PS_FOUND;
        end else begin
          state_next = ST_PT_CHK;
        end
      end
      ST_PT_CHK: state_next = (pt_dsq > {1'b0, ps_n}) ? ST_PS_FOUND : ST_PT_GO;
      ST_PT_GO: state_next = ST_PT_WAIT;
      ST_PT_WAIT: begin
        if (div_sts.done) state_next = (div_rem == '0) ? ST_PS_STEP : ST_PT_CHK;
      end
      ST_PS_FOUND: begin
        case (ps_ctx)
          PC_GROW: state_next = (ps_n <= NW'(MAX_SLOTS)) ? ST_PS_STEP : ST_DONE;
          PC_SHRINK: state_next = shrink_ok ? ST_PS_STEP : ST_DONE;
          default: state_next = ST_SWEEP;
        endcase
      end
      ST_RB_RD: state_next = ST_RB_EV;
      ST_RB_EV: state_next = is_full ? ST_HMOD_GO : ST_RB_NEXT;
      ST_RB_NEXT: state_next = (rb_src == table_size - 1'b1) ? ST_DONE : ST_RB_RD;
      ST_DONE: begin
        if (rsp_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory port, divider and handshake controls
  always_comb begin
    req_ready = (state == ST_IDLE);
    rd_addr = slot_addr(p_bank, pos);
    wr_en = 1'b0;
    wr_addr = slot_addr(p_bank, pos);
    wr_data = '{mark: MK_FULL, hash: p_hash, key: p_key, value: p_val};
    div_ctl.start = 1'b0;
    div_a = p_hash;
    div_b = NW'(p_size);
    case (state)
      ST_SWEEP: begin
        wr_en = 1'b1;
        wr_addr = slot_addr(sw_bank, sw_idx);
        wr_data = '{mark: MK_EMPTY, hash: '0, key: '0, value: '0};
      end
      ST_HMOD_GO: div_ctl.start = 1'b1;
      ST_SMOD_GO: begin
        div_ctl.start = 1'b1;
        div_b = NW'(p_sp);
      end
      ST_PROBE_EV: begin
        wr_en = pr_ok && (p_put || (op_func == FN_REMOVE));
        if (!p_put) begin
          wr_data = rd_q;
          wr_data.mark = MK_DELETED;
        end
      end
      ST_PT_GO: begin
        div_ctl.start = 1'b1;
        div_a = HASH_W'(ps_n);
        div_b = pt_d;
      end
      ST_RB_RD: rd_addr = slot_addr(active_bank, rb_src);
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
      sw_bank <= 1'b0;
      sw_idx <= '0;
      sw_end <= SW'(INIT_EFF);
      sw_ret <= ST_IDLE;
      active_bank <= 1'b0;
      table_size <= SW'(INIT_EFF);
      step_prime <= SW'(INIT_SP);
      element_count <= '0;
      probe_mode <= PM_LINEAR;
      max_load <= MAX_LOAD_RST;
      min_load <= MIN_LOAD_RST;
      rsp_valid <= 1'b0;
      rb_active <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg_wr) begin
        case (paddr[PADDR_W-1:2])
          REG_PROBE_MODE: probe_mode <= pwdata[1:0];
          REG_MAX_LOAD: max_load <= pwdata[7:0];
          REG_MIN_LOAD: min_load <= pwdata[7:0];
          default: ;
        endcase
      end

      // output register drains; a finishing transaction refills it below
      if (rsp_valid && rsp_ready && (state != ST_DONE)) rsp_valid <= 1'b0;

      case (state)
        ST_SWEEP: sw_idx <= sw_idx + 1'b1;

        // accept a transaction
        ST_IDLE: begin
          if (req_valid) begin
            op_func <= req.func;
            p_key <= req.item_key;
            p_hash <= req.key_hash;
            p_val <= req.item_value;
            p_bank <= active_bank;
            p_size <= table_size;
            p_sp <= step_prime;
            p_put <= (req.func == FN_PUT);
            res_status <= RS_SUCCESS;
            res_found <= 1'b0;
            res_value <= '0;
            rb_active <= 1'b0;
            if (req.func == FN_CLEAR) begin
              sw_bank <= active_bank;
              sw_idx <= '0;
              sw_end <= (table_size > SW'(INIT_EFF)) ? table_size : SW'(INIT_EFF);
              sw_ret <= ST_DONE;
              table_size <= SW'(INIT_EFF);
              step_prime <= SW'(INIT_SP);
              element_count <= '0;
            end
          end
        end

        // home slot and step
        ST_HMOD_WAIT: begin
          if (div_sts.done) begin
            pos <= SW'(div_rem);
            pi <= '0;
            delta <= SW'(1);
          end
        end
        ST_SMOD_WAIT: begin
          if (div_sts.done) delta <= p_sp - SW'(div_rem);
        end

        // evaluate the probed slot
        ST_PROBE_EV: begin
          if (pr_adv) begin
            pi <= pi + 1'b1;
            pos <= pos_next;
            if (probe_mode == PM_QUAD) delta <= delta_next;
          end
          if (pr_ok) begin
            if (p_put) begin
              if (!is_full) begin
                if (rb_active) rb_cnt <= rb_cnt + 1'b1;
                else element_count <= element_count + 1'b1;
              end
            end else if (op_func == FN_REMOVE) begin
              element_count <= element_count - 1'b1;
              res_found <= 1'b1;
            end else begin
              res_found <= 1'b1;
              res_value <= rd_q.value;
            end
          end
          if (pr_fail) res_status <= p_put ? RS_NO_ROOM : RS_NOT_FOUND;
        end

        // load checks start a prime search
        ST_GROW_CHK: begin
          ps_n <= NW'(table_size) << 1;
          ps_up <= 1'b1;
          ps_ctx <= PC_GROW;
        end
        ST_SHRINK_CHK: begin
          ps_n <= NW'(table_size >> 1);
          ps_up <= 1'b0;
          ps_ctx <= PC_SHRINK;
        end

        // next candidate
        ST_PS_STEP: begin
          pt_d <= NW'(2);
          pt_dsq <= (NW + 1)'(4);
          if (ps_up) begin
            if (ps_n > NW'(MAX_SLOTS)) ps_n <= NW'(MAX_SLOTS + 1);
            else ps_n <= ps_n + 1'b1;
          end else begin
            if (ps_n <= NW'(2)) ps_n <= NW'(1);
            else ps_n <= ps_n - 1'b1;
          end
        end

        // trial divisor did not divide: move to the next one
        ST_PT_WAIT: begin
          if (div_sts.done && (div_rem != '0)) begin
            pt_dsq <= pt_dsq + {pt_d, 1'b1};
            pt_d <= pt_d + 1'b1;
          end
        end

        // prime found or search ran out
        ST_PS_FOUND: begin
          case (ps_ctx)
            PC_GROW: begin
              if (ps_n <= NW'(MAX_SLOTS)) begin
                tgt_size <= SW'(ps_n);
                ps_up <= 1'b0;
                ps_ctx <= PC_NSP;
              end else begin
                res_status <= RS_NO_ROOM;
              end
            end
            PC_SHRINK: begin
              if (shrink_ok) begin
                tgt_size <= SW'(ps_n);
                ps_up <= 1'b0;
                ps_ctx <= PC_NSP;
              end
            end
            default: begin
              new_sp <= SW'(ps_n);
              sw_bank <= ~active_bank;
              sw_idx <= '0;
              sw_end <= tgt_size;
              sw_ret <= ST_RB_RD;
              rb_src <= '0;
              rb_cnt <= '0;
              rb_active <= 1'b1;
            end
          endcase
        end

        // re-insert a full slot of the old bank
        ST_RB_EV: begin
          if (is_full) begin
            p_key <= rd_q.key;
            p_hash <= rd_q.hash;
            p_val <= rd_q.value;
            p_bank <= ~active_bank;
            p_size <= tgt_size;
            p_sp <= new_sp;
            p_put <= 1'b1;
          end
        end
        ST_RB_NEXT: begin
          if (rb_src == table_size - 1'b1) begin
            active_bank <= ~active_bank;
            table_size <= tgt_size;
            step_prime <= new_sp;
            element_count <= rb_cnt;
            rb_active <= 1'b0;
          end else begin
            rb_src <= rb_src + 1'b1;
          end
        end

        // hand the result to the output register
        ST_DONE: begin
          rb_active <= 1'b0;
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            rsp.status <= res_status;
            rsp.found <= res_found;
            rsp.value_out <= res_value;
            rsp.entry_count <= COUNT_W'(element_count);
          end
        end
        default: ;
      endcase
    end
  end

  // checks
  `OAHT_CHECK(count_within_size, element_count <= table_size, "entry count exceeds table size")
  `OAHT_CHECK(step_below_size, step_prime < table_size, "step prime not below table size")
  `OAHT_CHECK(size_in_range, (table_size >= SW'(2)) && (table_size <= SW'(MAX_SLOTS)), "table size out of range")
  `OAHT_IMPLY(busy_after_accept, req_valid && req_ready, !req_ready, "ready right after a transaction")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// self-checking testbench for the open addressing hash table
// depends on oaht_pkg and the open_addressing_hash_table rtl
`timescale 1ns / 1ps

module tb_top;
  import oaht_pkg::*;

  localparam int SLOTS = 1024;
  localparam int INIT_SIZE = 11;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 200;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // shadow copy of the table
  logic [KEY_W-1:0] shadow_key[2*SLOTS];
  logic [VALUE_W-1:0] shadow_value[2*SLOTS];
  logic [HASH_W-1:0] shadow_hash[2*SLOTS];
  mark_t shadow_mark[2*SLOTS];
  int unsigned cur_bank;
  int unsigned cur_size;
  int unsigned cur_step;
  int unsigned cur_count;
  int unsigned cfg_probe;
  int unsigned cfg_max_load;
  int unsigned cfg_min_load;

  rsp_t expected_rsp_q[$];
  int errors;
  int n_items;
  int n_checked;
  int n_rebuilds;
  int n_no_room;
  int idle_cycles = 0;
  bit gaps_on;
  int rsp_hold = 0;

  // key pool for random traffic
  logic [KEY_W-1:0] pool_key[512];
  logic [HASH_W-1:0] pool_hash[512];

  open_addressing_hash_table u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------- table predictor ----------------

  function automatic bit prime_check(input int unsigned n);
    int unsigned d;
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++)
      if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int unsigned prime_under(input int unsigned n);
    int unsigned m;
    m = n;
    while (m > 2) begin
      m--;
      if (prime_check(m)) return m;
    end
    return 1;
  endfunction

  function automatic int unsigned prime_over(input int unsigned n);
    int unsigned m;
    m = n;
    while (m <= SLOTS) begin
      m++;
      if (prime_check(m)) return m;
    end
    return SLOTS + 1;
  endfunction

  function automatic int unsigned probe_index(input int unsigned h, input int unsigned i,
                                              input int unsigned sz,
                                              input int unsigned stp);
    longint unsigned p;
    int unsigned s;
    if (cfg_probe == PM_QUAD) begin
      p = longint'(h) + longint'(i) * longint'(i);
    end else if (cfg_probe == PM_DOUBLE) begin
      s = (stp != 0) ? stp : 1;
      p = longint'(h) + longint'(i) * longint'(s - h % s);
    end else begin
      p = longint'(h) + longint'(i);
    end
    return int'(p % longint'(sz));
  endfunction

  // slot a put lands in, or -1; hit set on a key match
  function automatic int find_put_slot(input int unsigned b, input int unsigned sz,
                                       input int unsigned stp, input logic [KEY_W-1:0] k,
                                       input logic [HASH_W-1:0] h, output bit hit);
    int unsigned i;
    int idx;
    hit = 1'b0;
    for (i = 0; i < sz; i++) begin
      idx = b * SLOTS + probe_index(h, i, sz, stp);
      if (shadow_mark[idx] != MK_FULL) return idx;
      if (shadow_key[idx] == k && shadow_hash[idx] == h) begin
        hit = 1'b1;
        return idx;
      end
    end
    return -1;
  endfunction

  function automatic int find_key(input logic [KEY_W-1:0] k, input logic [HASH_W-1:0] h);
    int unsigned i;
    int idx;
    for (i = 0; i < cur_size; i++) begin
      idx = cur_bank * SLOTS + probe_index(h, i, cur_size, cur_step);
      if (shadow_mark[idx] == MK_FULL) begin
        if (shadow_key[idx] == k && shadow_hash[idx] == h) return idx;
      end else if (shadow_mark[idx] == MK_EMPTY) begin
        break;
      end
    end
    return -1;
  endfunction

  // move every full slot into the other bank at a new size
  function automatic bit rehash_table(input int unsigned ns);
    int unsigned nb;
    int unsigned nstep;
    int unsigned cnt;
    int unsigned i;
    int src;
    int dst;
    bit hit;
    nb = cur_bank ^ 1;
    nstep = prime_under(ns);
    cnt = 0;
    for (i = 0; i < SLOTS; i++) shadow_mark[nb*SLOTS+i] = MK_EMPTY;
    for (i = 0; i < cur_size; i++) begin
      src = cur_bank * SLOTS + i;
      if (shadow_mark[src] != MK_FULL) continue;
      dst = find_put_slot(nb, ns, nstep, shadow_key[src], shadow_hash[src], hit);
      if (dst < 0) return 1'b0;
      shadow_key[dst] = shadow_key[src];
      shadow_hash[dst] = shadow_hash[src];
      shadow_value[dst] = shadow_value[src];
      shadow_mark[dst] = MK_FULL;
      if (!hit) cnt++;
    end
    cur_bank = nb;
    cur_size = ns;
    cur_step = nstep;
    cur_count = cnt;
    n_rebuilds++;
    return 1'b1;
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < 2*SLOTS; i++) shadow_mark[i] = MK_EMPTY;
    cur_bank = 0;
    cur_size = INIT_SIZE;
    cur_step = prime_under(INIT_SIZE);
    cur_count = 0;
    cfg_probe = PM_LINEAR;
    cfg_max_load = MAX_LOAD_RST;
    cfg_min_load = MIN_LOAD_RST;
  endfunction

  function automatic rsp_t table_apply(input req_t r);
    rsp_t o;
    int idx;
    bit hit;
    int unsigned ns;
    o = '0;
    o.status = RS_SUCCESS;
    case (r.func)
      FN_PUT: begin
        idx = find_put_slot(cur_bank, cur_size, cur_step, r.item_key, r.key_hash, hit);
        if (idx < 0) begin
          o.status = RS_NO_ROOM;
        end else begin
          shadow_key[idx] = r.item_key;
          shadow_hash[idx] = r.key_hash;
          shadow_value[idx] = r.item_value;
          shadow_mark[idx] = MK_FULL;
          if (!hit) cur_count++;
          if (longint'(cur_count) * 256 >= longint'(cfg_max_load) * cur_size) begin
            ns = prime_over(cur_size * 2);
            if (ns > SLOTS || !rehash_table(ns)) o.status = RS_NO_ROOM;
          end
        end
      end
      FN_GET, FN_REMOVE: begin
        idx = find_key(r.item_key, r.key_hash);
        if (idx < 0) begin
          o.status = RS_NOT_FOUND;
        end else if (r.func == FN_GET) begin
          o.found = 1'b1;
          o.value_out = shadow_value[idx];
        end else begin
          o.found = 1'b1;
          shadow_mark[idx] = MK_DELETED;
          cur_count--;
          if (cfg_min_load != 0 &&
              longint'(cur_count) * 256 <= longint'(cfg_min_load) * cur_size) begin
            ns = prime_under(cur_size / 2);
            if (ns >= 2 && ns > cur_count && !rehash_table(ns)) o.status = RS_NO_ROOM;
          end
        end
      end
      default: begin
        for (int i = 0; i < 2*SLOTS; i++) shadow_mark[i] = MK_EMPTY;
        cur_size = INIT_SIZE;
        cur_step = prime_under(INIT_SIZE);
        cur_count = 0;
      end
    endcase
    if (o.status == RS_NO_ROOM) n_no_room++;
    o.entry_count = cur_count[COUNT_W-1:0];
    return o;
  endfunction

  // ---------------- drivers ----------------

  // send one request transaction and record its expected response
  task automatic send_op(input func_t f, input logic [KEY_W-1:0] k,
                         input logic [HASH_W-1:0] h, input logic [VALUE_W-1:0] v);
    req_t r;
    int gap;
    r.func = f;
    r.item_key = k;
    r.key_hash = h;
    r.item_value = v;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp_q.push_back(table_apply(r));
    n_items++;
  endtask

  // wait for the block to go idle before touching registers
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input int unsigned data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(index) << 2;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (index)
      REG_PROBE_MODE: cfg_probe = data & 3;
      REG_MAX_LOAD: cfg_max_load = data & 8'hFF;
      default: cfg_min_load = data & 8'hFF;
    endcase
  endtask

  task automatic configure(input int unsigned mode, input int unsigned maxl,
                           input int unsigned minl);
    wait_idle();
    write_reg(REG_PROBE_MODE, mode);
    write_reg(REG_MAX_LOAD, maxl);
    write_reg(REG_MIN_LOAD, minl);
  endtask

  // ---------------- directed tests ----------------

  // field extremes, every operation, key match needs key and hash
  task automatic test_basic_ops();
    send_op(FN_PUT, 32'h0, 31'h0, 32'h0);
    send_op(FN_PUT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_op(FN_GET, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0);
    send_op(FN_GET, 32'hFFFF_FFFF, 31'h0, 32'h0);
    send_op(FN_PUT, 32'h0, 31'h0, 32'hA5A5_5A5A);
    send_op(FN_GET, 32'h0, 31'h0, 32'h0);
    send_op(FN_REMOVE, 32'h0, 31'h0, 32'h0);
    send_op(FN_REMOVE, 32'h0, 31'h0, 32'h0);
    send_op(FN_CLEAR, 32'h0, 31'h0, 32'h0);
    send_op(FN_GET, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0);
  endtask

  // quadratic probing on one hash runs out of slots before the table fills
  task automatic test_probe_exhaust();
    configure(PM_QUAD, 255, 0);
    for (int i = 0; i < 7; i++) send_op(FN_PUT, 32'h100 + i, 31'd5, $urandom);
    send_op(FN_CLEAR, 32'h0, 31'h0, 32'h0);
  endtask

  // every put grows until the next size is beyond capacity
  task automatic test_capacity();
    configure(3, 1, 0);
    for (int i = 0; i < 8; i++) send_op(FN_PUT, 32'h200 + i, 31'(i * 3), $urandom);
    send_op(FN_GET, 32'h203, 31'd9, 32'h0);
    send_op(FN_CLEAR, 32'h0, 31'h0, 32'h0);
  endtask

  // double hashing with removals pulling the table back down
  task automatic test_shrink();
    configure(PM_DOUBLE, 192, 128);
    for (int i = 0; i < 12; i++) send_op(FN_PUT, 32'h300 + i, 31'(i * 7 + 1), $urandom);
    for (int i = 0; i < 11; i++) send_op(FN_REMOVE, 32'h300 + i, 31'(i * 7 + 1), 32'h0);
    send_op(FN_GET, 32'h30B, 31'd78, 32'h0);
  endtask

  // ---------------- random traffic ----------------

  task automatic random_phase(input int n_ops, input int pool_n);
    int pick;
    int k;
    func_t f;
    logic [KEY_W-1:0] key;
    logic [HASH_W-1:0] hash;
    for (int i = 0; i < pool_n; i++) begin
      pool_key[i] = $urandom;
      pool_hash[i] = (i % 2 == 0) ? HASH_W'($urandom_range(0, 40)) : HASH_W'($urandom);
    end
    for (int n = 0; n < n_ops; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) f = FN_PUT;
      else if (pick < 70) f = FN_GET;
      else if (pick < 98) f = FN_REMOVE;
      else f = FN_CLEAR;
      k = $urandom_range(0, pool_n - 1);
      key = pool_key[k];
      hash = pool_hash[k];
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        key = $urandom;
        hash = HASH_W'($urandom);
      end else if (pick < 12) begin
        hash = hash ^ HASH_W'(1 << $urandom_range(0, HASH_W - 1));
      end
      send_op(f, key, hash, $urandom);
    end
  endtask

  task automatic test_random();
    random_phase(150, 40);
    configure(PM_QUAD, 255, 0);
    random_phase(120, 30);
    configure(PM_DOUBLE, 96, 32);
    random_phase(150, 120);
    configure(3, 1, 254);
    random_phase(60, 20);
    configure(PM_LINEAR, 200, 64);
    random_phase(150, 300);
    configure(PM_DOUBLE, 255, 0);
    random_phase(100, 60);
    // final stretch runs back to back on both sides
    gaps_on = 1'b0;
    random_phase(150, 50);
  endtask

  // ---------------- response checking ----------------

  always @(posedge clk) begin
    rsp_t exp_r;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsp_q.size() == 0) begin
        $display("%0t: unexpected response, actual %p", $time, rsp);
        errors++;
      end else begin
        exp_r = expected_rsp_q.pop_front();
        n_checked++;
        if (rsp.status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, rsp.status);
          errors++;
        end
        if (rsp.found !== exp_r.found) begin
          $display("%0t: found expected %0d actual %0d", $time, exp_r.found, rsp.found);
          errors++;
        end
        if (rsp.value_out !== exp_r.value_out) begin
          $display("%0t: value_out expected %h actual %h", $time, exp_r.value_out,
                   rsp.value_out);
          errors++;
        end
        if (rsp.entry_count !== exp_r.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, exp_r.entry_count,
                   rsp.entry_count);
          errors++;
        end
      end
    end
  end

  // response side back-pressure in short bursts
  always @(posedge clk) begin
    if (rsp_hold > 0) begin
      rsp_hold <= rsp_hold - 1;
      rsp_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 3) == 0) begin
      rsp_hold <= $urandom_range(0, 2);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    n_items = 0;
    n_checked = 0;
    n_rebuilds = 0;
    n_no_room = 0;
    gaps_on = 1'b1;
    table_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_probe_exhaust();
    test_capacity();
    test_shrink();
    test_random();
    wait_idle();
    $display("covered %0d operations, %0d responses checked, %0d table rebuilds,",
             n_items, n_checked, n_rebuilds);
    $display("%0d no-room responses, all probe modes and load threshold extremes",
             n_no_room);
    if (errors == 0 && expected_rsp_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0t: %0d mismatches, %0d responses missing", $time, errors,
               expected_rsp_q.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
